// File: hw/rtl/imdlp_pkg.sv
// Shared types, constants and helper functions for the display list parser.
package imdlp_pkg;

  localparam int NUM_ATTRIBUTES = 21;
  localparam int ATTR_W         = $clog2(NUM_ATTRIBUTES);
  localparam int S_W            = ATTR_W + 1;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 2 * NUM_ATTRIBUTES;
  localparam int QDEPTH         = 4;
  localparam int Q_AW           = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMATS = 1'd1;

  // Attribute index formats
  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_DIRECT = 2'd1;
  localparam logic [1:0] FMT_BYTE   = 2'd2;
  localparam logic [1:0] FMT_SHORT  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_IDX = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CMD   = 3'd1;
  localparam logic [2:0] ERR_BAD_BYTE  = 3'd2;
  localparam logic [2:0] ERR_BAD_SHORT = 3'd3;
  localparam logic [2:0] ERR_DIRECT    = 3'd4;
  localparam logic [2:0] ERR_TRUNC     = 3'd5;

  // Direct format is only legal below this attribute
  localparam logic [ATTR_W-1:0] DIRECT_LIMIT = ATTR_W'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_list;
  } imdlp_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  draw_tag;
    logic [15:0] vertex_count;
    logic [15:0] vertex_number;
    logic [4:0]  attribute_number;
    logic [15:0] index_value;
    logic [15:0] max_index_seen;
    logic [2:0]  error_code;
    logic        last_of_run;
  } imdlp_out_t;

  // Everything one byte produces: a leading result, two runs of no-byte
  // indices (current vertex, then next vertex) and a trailing error.
  typedef struct packed {
    logic [7:0]                tag;
    logic [15:0]               count;
    logic                      first_v;
    logic [1:0]                first_kind;
    logic [15:0]               first_vnum;
    logic [ATTR_W-1:0]         first_attr;
    logic [15:0]               first_val;
    logic [2:0]                first_code;
    logic [NUM_ATTRIBUTES-1:0] mask_a;
    logic [15:0]               vnum_a;
    logic [NUM_ATTRIBUTES-1:0] mask_b;
    logic                      tail_v;
    logic [2:0]                tail_code;
    logic [15:0]               tail_vnum;
    logic [ATTR_W-1:0]         tail_attr;
  } imdlp_rec_t;

  // Position of the lowest set bit; zero when none is set.
  function automatic logic [ATTR_W-1:0] lowest_set(input logic [NUM_ATTRIBUTES-1:0] m);
    logic [ATTR_W-1:0] res;
    res = '0;
    for (int i = NUM_ATTRIBUTES - 1; i >= 0; i--) begin
      if (m[i]) res = ATTR_W'(i);
    end
    return res;
  endfunction

  // Bits at or above position s.
  function automatic logic [NUM_ATTRIBUTES-1:0] ge_mask(input logic [S_W-1:0] s);
    logic [NUM_ATTRIBUTES-1:0] m;
    for (int i = 0; i < NUM_ATTRIBUTES; i++) begin
      m[i] = (S_W'(i) >= s);
    end
    return m;
  endfunction

  // Bits below position p.
  function automatic logic [NUM_ATTRIBUTES-1:0] lt_mask(input logic [ATTR_W-1:0] p);
    logic [NUM_ATTRIBUTES-1:0] m;
    for (int i = 0; i < NUM_ATTRIBUTES; i++) begin
      m[i] = (ATTR_W'(i) < p);
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/imdlp_front.sv
// Front end: configuration, byte parsing and per-byte result records.
module imdlp_front import imdlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imdlp_in_t             in_data,
  output logic                  q_push,
  output imdlp_rec_t            q_rec,
  input  logic                  q_full
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CNT_HI, PH_CNT_LO, PH_IDX, PH_IDX_LO
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [7:0]                      tag_r, tag_nxt;
  logic [15:0]                     count_r, count_nxt;
  logic [15:0]                     vc_r, vc_nxt;
  logic [ATTR_W-1:0]               cursor_r, cursor_nxt;
  logic [7:0]                      partial_r, partial_nxt;
  logic                            latched_r, latched_nxt;
  logic [NUM_ATTRIBUTES-1:0]       enable_r;
  logic [NUM_ATTRIBUTES-1:0][1:0]  fmt_r;

  logic [NUM_ATTRIBUTES-1:0] stop_mask, none_mask;
  logic                      accept;
  logic [7:0]                b;
  logic                      eol;
  logic [15:0]               short_val;
  logic                      err_now, bad_tag, walk_do;
  imdlp_rec_t                rec;

  logic [S_W-1:0]            walk_s;
  logic [15:0]               walk_vc, walk_cnt;
  logic [NUM_ATTRIBUTES-1:0] w_mask_a, w_mask_b, w_ge, w_hi;
  logic [15:0]               w_vc, w_inc;
  logic [ATTR_W-1:0]         w_cursor, w_p;
  logic                      w_idle, w_err4, w_found;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign b         = in_data.data_byte;
  assign eol       = in_data.end_of_list;
  assign short_val = {partial_r, b};

  always_comb begin
    for (int i = 0; i < NUM_ATTRIBUTES; i++) begin
      stop_mask[i] = enable_r[i] && (fmt_r[i] != FMT_NONE);
      none_mask[i] = enable_r[i] && (fmt_r[i] == FMT_NONE);
    end
  end

  // Walk forward from walk_s to the next attribute that takes a byte,
  // wrapping into the next vertex at most once.
  always_comb begin
    w_ge     = ge_mask(walk_s);
    w_hi     = stop_mask & w_ge;
    w_inc    = walk_vc + 16'd1;
    w_mask_a = '0;
    w_mask_b = '0;
    w_vc     = walk_vc;
    w_cursor = '0;
    w_p      = '0;
    w_idle   = 1'b0;
    w_err4   = 1'b0;
    w_found  = 1'b0;
    if (|w_hi) begin
      w_p      = lowest_set(w_hi);
      w_found  = 1'b1;
      w_mask_a = none_mask & w_ge & lt_mask(w_p);
    end else begin
      w_mask_a = none_mask & w_ge;
      w_vc     = w_inc;
      if (w_inc == walk_cnt) begin
        w_idle = 1'b1;
      end else if (|stop_mask) begin
        w_p      = lowest_set(stop_mask);
        w_found  = 1'b1;
        w_mask_b = none_mask & lt_mask(w_p);
      end else begin
        w_idle = 1'b1;
      end
    end
    if (w_found) begin
      w_cursor = w_p;
      if (fmt_r[w_p] == FMT_DIRECT && w_p >= DIRECT_LIMIT) w_err4 = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    count_nxt   = count_r;
    vc_nxt      = vc_r;
    cursor_nxt  = cursor_r;
    partial_nxt = partial_r;
    latched_nxt = latched_r;
    rec         = '0;
    err_now     = 1'b0;
    bad_tag     = 1'b0;
    walk_do     = 1'b0;
    walk_s      = {1'b0, cursor_r} + S_W'(1);
    walk_vc     = vc_r;
    walk_cnt    = count_r;

    if (latched_r) begin
      // Drop bytes until the list ends
      if (eol) begin
        latched_nxt = 1'b0;
        phase_nxt   = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (b != 8'h00) begin
            if (!b[7]) begin
              rec.first_v    = 1'b1;
              rec.first_kind = KIND_ERR;
              rec.first_code = ERR_BAD_CMD;
              rec.first_vnum = vc_r;
              rec.first_attr = cursor_r;
              err_now        = 1'b1;
              bad_tag        = 1'b1;
            end else begin
              tag_nxt   = b;
              phase_nxt = PH_CNT_HI;
            end
          end
        end
        PH_CNT_HI: begin
          partial_nxt = b;
          phase_nxt   = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          count_nxt      = short_val;
          vc_nxt         = '0;
          cursor_nxt     = '0;
          rec.first_v    = 1'b1;
          rec.first_kind = KIND_HDR;
          walk_s         = '0;
          walk_vc        = '0;
          walk_cnt       = short_val;
          phase_nxt      = PH_IDLE;
          if (short_val != 16'd0 && |stop_mask) walk_do = 1'b1;
        end
        PH_IDX: begin
          if (fmt_r[cursor_r] == FMT_SHORT) begin
            partial_nxt = b;
            phase_nxt   = PH_IDX_LO;
          end else if (b == 8'hff) begin
            rec.first_v    = 1'b1;
            rec.first_kind = KIND_ERR;
            rec.first_code = ERR_BAD_BYTE;
            rec.first_vnum = vc_r;
            rec.first_attr = cursor_r;
            rec.first_val  = {8'h00, b};
            err_now        = 1'b1;
          end else begin
            rec.first_v    = 1'b1;
            rec.first_kind = KIND_IDX;
            rec.first_vnum = vc_r;
            rec.first_attr = cursor_r;
            rec.first_val  = {8'h00, b};
            walk_do        = 1'b1;
          end
        end
        PH_IDX_LO: begin
          rec.first_v    = 1'b1;
          rec.first_vnum = vc_r;
          rec.first_attr = cursor_r;
          rec.first_val  = short_val;
          if (short_val == 16'hffff) begin
            rec.first_kind = KIND_ERR;
            rec.first_code = ERR_BAD_SHORT;
            err_now        = 1'b1;
          end else begin
            rec.first_kind = KIND_IDX;
            walk_do        = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (walk_do) begin
        rec.mask_a = w_mask_a;
        rec.vnum_a = walk_vc;
        rec.mask_b = w_mask_b;
        vc_nxt     = w_vc;
        cursor_nxt = w_cursor;
        phase_nxt  = (w_idle || w_err4) ? PH_IDLE : PH_IDX;
        if (w_err4) begin
          rec.tail_v    = 1'b1;
          rec.tail_code = ERR_DIRECT;
          rec.tail_vnum = w_vc;
          rec.tail_attr = w_cursor;
          err_now       = 1'b1;
        end
      end

      if (err_now) begin
        latched_nxt = 1'b1;
        phase_nxt   = PH_IDLE;
      end

      if (eol) begin
        // Flag an unfinished command at the end of the list
        if (!err_now && phase_nxt != PH_IDLE) begin
          rec.tail_v    = 1'b1;
          rec.tail_code = ERR_TRUNC;
          rec.tail_vnum = vc_nxt;
          rec.tail_attr = cursor_nxt;
        end
        phase_nxt   = PH_IDLE;
        latched_nxt = 1'b0;
      end

      rec.tag   = bad_tag ? b : tag_nxt;
      rec.count = count_nxt;
    end
  end

  assign q_rec  = rec;
  assign q_push = accept && (rec.first_v || (|rec.mask_a) || (|rec.mask_b) || rec.tail_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tag_r     <= '0;
      count_r   <= '0;
      vc_r      <= '0;
      cursor_r  <= '0;
      partial_r <= '0;
      latched_r <= 1'b0;
      enable_r  <= '0;
      fmt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:  enable_r <= cfg_wdata[NUM_ATTRIBUTES-1:0];
          REG_FORMATS: fmt_r    <= cfg_wdata[CFG_DATA_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        tag_r     <= tag_nxt;
        count_r   <= count_nxt;
        vc_r      <= vc_nxt;
        cursor_r  <= cursor_nxt;
        partial_r <= partial_nxt;
        latched_r <= latched_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/imdlp_queue.sv
// Short record queue between the parser front end and the emitter.
module imdlp_queue import imdlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  imdlp_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output imdlp_rec_t head,
  output logic       head_valid
);

  imdlp_rec_t        mem_r [QDEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;

  assign full       = (count_r == (Q_AW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + (Q_AW+1)'(1);
    if (pop && !push) count_nxt = count_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

// File: hw/rtl/imdlp_back.sv
// Back end: expands records into results and keeps the per-attribute maximum.
module imdlp_back import imdlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  imdlp_rec_t q_head,
  input  logic       q_valid,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output imdlp_out_t out_data
);

  logic                      busy_r;
  imdlp_rec_t                cur_r;
  logic                      out_valid_r;
  imdlp_out_t                out_data_r;
  logic [15:0]               tbl_r [NUM_ATTRIBUTES];

  imdlp_rec_t        src, rem;
  logic              src_v, fire, last, is_idx, upd;
  imdlp_out_t        e;
  logic [ATTR_W-1:0] attr;
  logic [15:0]       val, rd, new_max;

  assign src   = busy_r ? cur_r : q_head;
  assign src_v = busy_r || q_valid;
  assign fire  = src_v && (!out_valid_r || out_ready);
  assign q_pop = fire && !busy_r;

  always_comb begin
    rem    = src;
    e      = '0;
    attr   = '0;
    val    = '0;
    is_idx = 1'b0;
    e.draw_tag     = src.tag;
    e.vertex_count = src.count;
    if (src.first_v) begin
      rem.first_v     = 1'b0;
      e.item_kind     = src.first_kind;
      e.vertex_number = src.first_vnum;
      e.error_code    = src.first_code;
      attr            = src.first_attr;
      val             = src.first_val;
      is_idx          = (src.first_kind == KIND_IDX);
    end else if (|src.mask_a) begin
      attr              = lowest_set(src.mask_a);
      rem.mask_a[attr]  = 1'b0;
      e.item_kind       = KIND_IDX;
      e.vertex_number   = src.vnum_a;
      is_idx            = 1'b1;
    end else if (|src.mask_b) begin
      attr              = lowest_set(src.mask_b);
      rem.mask_b[attr]  = 1'b0;
      e.item_kind       = KIND_IDX;
      e.vertex_number   = src.vnum_a + 16'd1;
      is_idx            = 1'b1;
    end else begin
      rem.tail_v      = 1'b0;
      e.item_kind     = KIND_ERR;
      e.vertex_number = src.tail_vnum;
      e.error_code    = src.tail_code;
      attr            = src.tail_attr;
    end

    // Attribute zero never enters the table
    upd     = is_idx && (attr != '0) && (attr < ATTR_W'(NUM_ATTRIBUTES));
    rd      = upd ? tbl_r[attr] : 16'd0;
    new_max = (rd <= val) ? val : rd;

    e.attribute_number = 5'(attr);
    e.index_value      = val;
    e.max_index_seen   = upd ? new_max : 16'd0;
    last = !(rem.first_v || (|rem.mask_a) || (|rem.mask_b) || rem.tail_v);
    e.last_of_run = last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_ATTRIBUTES; i++) tbl_r[i] <= '0;
    end else begin
      out_valid_r <= fire || (out_valid_r && !out_ready);
      if (fire) begin
        busy_r <= !last;
        if (upd) tbl_r[attr] <= new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_r      <= rem;
      out_data_r <= e;
    end
  end

endmodule

// File: hw/rtl/indexed_mesh_display_list_parser_top.sv
// Top level of the indexed mesh display list parser.
//
//  channel | ports                          | moves
//  --------+--------------------------------+----------------------------------
//  input   | in_valid/in_ready/in_data      | one list byte per item
//  result  | out_valid/out_ready/out_data   | one header, index or error item
//  config  | cfg_we/cfg_index/cfg_wdata     | attribute enable / format write
//
// A byte that yields zero or one result item is taken every cycle unless the
// queue is full. A byte that yields more items holds the emitter, one item per
// cycle unless stalled, as each index goes through the single read-modify-write
// port of the maximum table; a four-record queue lets the parser keep taking
// bytes meanwhile. Reset is synchronous and clears the parse state, registers,
// queue and maximum table. A stalled result holds in the output register.
module indexed_mesh_display_list_parser_top import imdlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imdlp_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imdlp_out_t            out_data
);

  logic       q_push, q_full, q_pop, q_valid;
  imdlp_rec_t q_rec, q_head;

  // Parse: walk the phase machine, classify each byte into a result record
  imdlp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_rec     (q_rec),
    .q_full    (q_full)
  );

  // Buffer records so either side can stall on its own
  imdlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // Emit: expand each record into items and update the running maxima
  imdlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/imdlp_checker.sv
// Port-level checks for the display list parser, bound to the top level.
module imdlp_checker import imdlp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_valid,
  input logic                  in_ready,
  input imdlp_in_t             in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input imdlp_out_t            out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_HDR |->
      out_data.vertex_number == 16'd0 && out_data.attribute_number == 5'd0 &&
      out_data.index_value == 16'd0 && out_data.max_index_seen == 16'd0 &&
      out_data.error_code == ERR_NONE)
    else $error("header carries index fields");

  a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_ERR |->
      out_data.error_code != ERR_NONE && out_data.max_index_seen == 16'd0 &&
      out_data.last_of_run)
    else $error("error item malformed");

  a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_IDX && out_data.attribute_number != 5'd0 |->
      out_data.max_index_seen >= out_data.index_value)
    else $error("running maximum below index");

endmodule

bind indexed_mesh_display_list_parser_top imdlp_checker u_imdlp_checker (.*);
